@@ rtl/core/mms_pkg.sv @@
// Shared constants, action codes and controller/datapath command types for the stack.
`timescale 1ns / 1ps

package mms_pkg;

  localparam int DEPTH = 64;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam int WORD_W = 32;
  localparam int COUNT_W = 7;

  localparam logic [WORD_W-1:0] MIN_START = 32'd2147483647;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic scan;
    logic load_out;
  } mms_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic out_free;
  } mms_sts_t;

endpackage

@@ rtl/core/mms_req_if.sv @@
// Request and response channel interfaces with valid/ready handshakes.
`timescale 1ns / 1ps

interface mms_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic [mms_pkg::WORD_W-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface

interface mms_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [mms_pkg::WORD_W-1:0]  data;
  logic [mms_pkg::COUNT_W-1:0] count;
  logic [mms_pkg::WORD_W-1:0]  min_value;
  logic [mms_pkg::WORD_W-1:0]  max_value;

  modport source (output valid, output ok, output data, output count,
                  output min_value, output max_value, input ready);
  modport sink (input valid, input ok, input data, input count,
                input min_value, input max_value, output ready);
endinterface

@@ rtl/core/mms_ctrl.sv @@
// Controller state machine sequencing accept, execute, rescan and result hand-off.
`timescale 1ns / 1ps

module mms_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  mms_pkg::mms_sts_t sts,
  output mms_pkg::mms_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.need_scan ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/mms_dp.sv @@
// Datapath: stack memory, fill level, running extremes, rescan unit and result register.
`timescale 1ns / 1ps

module mms_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  mms_pkg::mms_cmd_t           cmd,
  output mms_pkg::mms_sts_t           sts,
  input  logic [1:0]                  req_action,
  input  logic [mms_pkg::WORD_W-1:0]  req_value,
  input  logic                        rsp_ready,
  output logic                        rsp_valid,
  output logic                        rsp_ok,
  output logic [mms_pkg::WORD_W-1:0]  rsp_data,
  output logic [mms_pkg::COUNT_W-1:0] rsp_count,
  output logic [mms_pkg::WORD_W-1:0]  rsp_min_value,
  output logic [mms_pkg::WORD_W-1:0]  rsp_max_value
);

  logic [mms_pkg::WORD_W-1:0] mem [mms_pkg::DEPTH];
  logic [mms_pkg::AW-1:0]     rd_addr;
  logic [mms_pkg::WORD_W-1:0] rdata;
  logic                       wr_en;

  mms_pkg::action_t           act;
  logic [mms_pkg::WORD_W-1:0] act_value;
  logic [mms_pkg::CW-1:0]     fill;
  logic [mms_pkg::CW-1:0]     fill_m1;
  logic [mms_pkg::WORD_W-1:0] run_min;
  logic [mms_pkg::WORD_W-1:0] run_max;
  logic                       res_ok;
  logic [mms_pkg::WORD_W-1:0] res_data;

  logic [mms_pkg::CW-1:0]     scan_idx;
  logic                       rd_valid;
  logic [mms_pkg::WORD_W-1:0] acc_min;
  logic [mms_pkg::WORD_W-1:0] acc_max;
  logic                       fix_min;
  logic                       fix_max;

  logic not_empty;
  logic not_full;
  logic hit_min;
  logic hit_max;
  logic scan_more;

  assign fill_m1   = fill - mms_pkg::CW'(1);
  assign not_empty = (fill != '0);
  assign not_full  = (fill < mms_pkg::CW'(mms_pkg::DEPTH));
  assign hit_min   = (rdata == run_min);
  assign hit_max   = (rdata == run_max);
  assign scan_more = (scan_idx < fill);

  assign sts.need_scan = (act == mms_pkg::ACT_POP) && not_empty && (hit_min || hit_max);
  assign sts.scan_done = !rd_valid && !scan_more;
  assign sts.out_free  = !rsp_valid || rsp_ready;

  // Outside a rescan the read port always looks at the top entry.
  assign rd_addr = cmd.scan ? scan_idx[mms_pkg::AW-1:0] : fill_m1[mms_pkg::AW-1:0];
  assign wr_en   = cmd.exec && (act == mms_pkg::ACT_PUSH) && not_full;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill[mms_pkg::AW-1:0]] <= act_value;
    end
    rdata <= mem[rd_addr];
  end

  // Control state and running extremes.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      run_min   <= mms_pkg::MIN_START;
      run_max   <= '0;
      rd_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        rd_valid <= 1'b0;
        case (act)
          mms_pkg::ACT_PUSH: begin
            if (not_full) begin
              fill <= fill + mms_pkg::CW'(1);
              if (act_value < run_min) begin
                run_min <= act_value;
              end
              if (act_value > run_max) begin
                run_max <= act_value;
              end
            end
          end
          mms_pkg::ACT_POP: begin
            if (not_empty) begin
              fill <= fill_m1;
            end
          end
          mms_pkg::ACT_PEEK: begin
          end
          mms_pkg::ACT_CLEAR: begin
            fill    <= '0;
            run_min <= mms_pkg::MIN_START;
            run_max <= '0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.scan) begin
        rd_valid <= scan_more;
        if (sts.scan_done) begin
          if (fix_min) begin
            run_min <= acc_min;
          end
          if (fix_max) begin
            run_max <= acc_max;
          end
        end
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act       <= mms_pkg::action_t'(req_action);
      act_value <= req_value;
    end
    if (cmd.exec) begin
      scan_idx <= '0;
      acc_min  <= mms_pkg::MIN_START;
      acc_max  <= '0;
      fix_min  <= hit_min;
      fix_max  <= hit_max;
      case (act)
        mms_pkg::ACT_PUSH: begin
          res_ok   <= not_full;
          res_data <= '0;
        end
        mms_pkg::ACT_POP, mms_pkg::ACT_PEEK: begin
          res_ok   <= not_empty;
          res_data <= not_empty ? rdata : '0;
        end
        default: begin
          res_ok   <= 1'b1;
          res_data <= '0;
        end
      endcase
    end
    if (cmd.scan) begin
      if (scan_more) begin
        scan_idx <= scan_idx + mms_pkg::CW'(1);
      end
      if (rd_valid) begin
        if (rdata < acc_min) begin
          acc_min <= rdata;
        end
        if (rdata > acc_max) begin
          acc_max <= rdata;
        end
      end
    end
    if (cmd.load_out) begin
      rsp_ok        <= res_ok;
      rsp_data      <= res_data;
      rsp_count     <= mms_pkg::COUNT_W'(fill);
      rsp_min_value <= run_min;
      rsp_max_value <= run_max;
    end
  end

endmodule

@@ rtl/core/min_max_tracking_stack.sv @@
// Top level of the min/max tracking stack: controller, datapath and channel wiring.
`timescale 1ns / 1ps

// A bounded last-in first-out stack of 32-bit words (64 deep) that also reports the
// running minimum and maximum of what it holds; the minimum starts from 2147483647, so
// a held word above that value never becomes the reported minimum. Each request beat
// carries an action (push, pop, peek at the top, or clear) and, for a push, the word to
// store; each request produces exactly one response beat with a success flag, the popped
// or peeked word, the number of entries held and the current extremes. A pop that removes
// the word equal to the minimum or the maximum rescans the remaining entries through the
// single read port of the stack memory, one entry per cycle, before its response is
// loaded. Requests are taken one at a time: the request channel is ready only while no
// request is in progress. The response register lets a new request be accepted while the
// previous response still waits to be taken. The stack memory needs no clearing after
// reset, as only entries that have been written are ever used.
module min_max_tracking_stack (
  input logic       clk,
  input logic       rst,
  mms_req_if.sink   req,
  mms_rsp_if.source rsp
);

  mms_pkg::mms_cmd_t cmd;
  mms_pkg::mms_sts_t sts;

  // The controller owns the request handshake and sequences the datapath.
  mms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the stack, the extremes and the response register.
  mms_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_action    (req.action),
    .req_value     (req.value),
    .rsp_ready     (rsp.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ok        (rsp.ok),
    .rsp_data      (rsp.data),
    .rsp_count     (rsp.count),
    .rsp_min_value (rsp.min_value),
    .rsp_max_value (rsp.max_value)
  );

endmodule

@@ rtl/core/mms_checker.sv @@
// Port-level checker for the min/max tracking stack and its bind statement.
`timescale 1ns / 1ps

module mms_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic                        rsp_ok,
  input logic [mms_pkg::WORD_W-1:0]  rsp_data,
  input logic [mms_pkg::COUNT_W-1:0] rsp_count,
  input logic [mms_pkg::WORD_W-1:0]  rsp_min_value,
  input logic [mms_pkg::WORD_W-1:0]  rsp_max_value
);

  // A response never appears in the cycle straight after a request beat.
  a_no_instant_rsp: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !$rose(rsp_valid))
    else $error("response appeared one cycle after a request beat");

  // An empty stack reports the starting extremes.
  a_empty_extremes: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_count == '0) |->
      (rsp_max_value == '0 && rsp_min_value == mms_pkg::MIN_START))
    else $error("empty stack reports stale extremes");

  // With entries held, the minimum never exceeds the maximum.
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_count != '0) |-> (rsp_min_value <= rsp_max_value))
    else $error("minimum above maximum");

  // A stalled response beat holds its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_ok) && $stable(rsp_data) && $stable(rsp_count)
       && $stable(rsp_min_value) && $stable(rsp_max_value)))
    else $error("stalled response beat changed");

endmodule

bind min_max_tracking_stack mms_checker u_mms_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_ok        (rsp.ok),
  .rsp_data      (rsp.data),
  .rsp_count     (rsp.count),
  .rsp_min_value (rsp.min_value),
  .rsp_max_value (rsp.max_value)
);
